>>> rtl/lzrw_pkg.sv
// Shared types and constants of the LZRW1 stream decompressor.
package lzrw_pkg;

    localparam int WIN_BYTES = 4096;
    localparam int WIN_AW    = 12;
    localparam int FILL_W    = WIN_AW + 1;
    localparam int RUN_W     = 5;
    localparam int GROUP_LEN = 16;
    localparam int MIN_MATCH = 3;

    localparam logic [7:0] LEN_MASK = 8'h0F;
    localparam logic [7:0] OFS_MASK = 8'hF0;

    typedef enum logic [1:0] {
        PH_CTRL_LO = 2'd0,
        PH_CTRL_HI = 2'd1,
        PH_ITEM    = 2'd2,
        PH_COPY2   = 2'd3
    } phase_t;

    // controller -> datapath
    typedef struct packed {
        logic take;   // input transfer this cycle
        logic rd;     // issue history read
        logic emit;   // write history and load output register
    } lzrw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic go_lit;    // incoming byte is a literal
        logic go_copy;   // incoming byte completes a copy item
        logic out_free;  // output register can take a byte
        logic last;      // byte about to be emitted ends the run
    } lzrw_stat_t;

endpackage

>>> rtl/lzrw_in_if.sv
// Compressed byte channel: valid/ready with comp_byte and new_stream.
interface lzrw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] comp_byte;
    logic       new_stream;

    modport source (output valid, output comp_byte, output new_stream, input ready);
    modport sink   (input valid, input comp_byte, input new_stream, output ready);
endinterface

>>> rtl/lzrw_out_if.sv
// Decompressed byte channel: valid/ready with out_byte, run_last and bad_offset.
interface lzrw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       bad_offset;

    modport source (output valid, output out_byte, output run_last, output bad_offset,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input bad_offset,
                    output ready);
endinterface

>>> rtl/lzrw_ctrl.sv
// Sequencing state machine: input transfers, history reads and byte emission.
module lzrw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lzrw_pkg::lzrw_stat_t stat,
    output lzrw_pkg::lzrw_cmd_t  cmd
);
    import lzrw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.take = in_valid && (state_reg == S_IDLE);
        cmd.rd   = (state_reg == S_READ);
        cmd.emit = (state_reg == S_EMIT) && stat.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.take)
                begin
                    if (stat.go_lit)
                        state_next = S_EMIT;
                    else if (stat.go_copy)
                        state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_EMIT;
            S_EMIT:
            begin
                if (cmd.emit)
                    state_next = stat.last ? S_IDLE : S_READ;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/lzrw_dp.sv
// Parse registers, history window, copy pointers and output register.
module lzrw_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzrw_pkg::lzrw_cmd_t  cmd,
    output lzrw_pkg::lzrw_stat_t stat,
    input  logic [7:0]           comp_byte,
    input  logic                 new_stream,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 run_last,
    output logic                 bad_offset
);
    import lzrw_pkg::*;

    // parse state
    logic [15:0]      ctrl_word_reg, ctrl_word_next, cw_eff;
    logic [RUN_W-1:0] left_reg, left_next, left_eff;
    phase_t           phase_reg, phase_next, phase_eff;
    logic [7:0]       held_reg, held_next, held_eff;

    // copy run
    logic [WIN_AW-1:0] wp_reg;
    logic [FILL_W-1:0] fill_reg;       // bytes written since stream start, saturating
    logic [WIN_AW-1:0] offset_reg;
    logic [RUN_W-1:0]  remain_reg;
    logic              bad_reg;
    logic              lit_reg;
    logic [7:0]        byte_reg;

    logic [7:0]        hist_mem [WIN_BYTES];
    logic [7:0]        rd_data_reg;
    logic              rd_ok_reg;
    logic [WIN_AW-1:0] rd_addr;
    logic [WIN_AW-1:0] new_offset;
    logic [7:0]        emit_val;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg;
    logic              bad_offset_reg;

    // state as seen by the incoming byte (new_stream clears it first)
    always_comb
    begin
        cw_eff    = new_stream ? '0 : ctrl_word_reg;
        left_eff  = new_stream ? '0 : left_reg;
        phase_eff = new_stream ? PH_CTRL_LO : phase_reg;
        held_eff  = new_stream ? '0 : held_reg;
    end

    // offset = high nibble of the first byte above the second byte
    assign new_offset   = {held_eff & OFS_MASK, 4'h0} | {4'h0, comp_byte};
    assign stat.go_lit  = (phase_eff == PH_ITEM) && !cw_eff[0];
    assign stat.go_copy = (phase_eff == PH_COPY2);

    always_comb
    begin
        ctrl_word_next = cw_eff;
        left_next      = left_eff;
        phase_next     = phase_eff;
        held_next      = held_eff;
        case (phase_eff)
            PH_CTRL_LO:
            begin
                ctrl_word_next = {8'h00, comp_byte};
                phase_next     = PH_CTRL_HI;
            end
            PH_CTRL_HI:
            begin
                ctrl_word_next = {comp_byte, cw_eff[7:0]};
                left_next      = RUN_W'(GROUP_LEN);
                phase_next     = PH_ITEM;
            end
            PH_ITEM:
            begin
                if (cw_eff[0])
                begin
                    held_next  = comp_byte;
                    phase_next = PH_COPY2;
                end
            end
            default:
                ;
        endcase
        // item complete: literal or second byte of a copy
        if (stat.go_lit || stat.go_copy)
        begin
            ctrl_word_next = cw_eff >> 1;
            if (left_eff <= RUN_W'(1))
            begin
                left_next  = '0;
                phase_next = PH_CTRL_LO;
            end
            else
            begin
                left_next  = left_eff - RUN_W'(1);
                phase_next = PH_ITEM;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_word_reg <= '0;
            left_reg      <= '0;
            phase_reg     <= PH_CTRL_LO;
            held_reg      <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                ctrl_word_reg <= ctrl_word_next;
                left_reg      <= left_next;
                phase_reg     <= phase_next;
                held_reg      <= held_next;
                if (new_stream)
                begin
                    wp_reg   <= '0;
                    fill_reg <= '0;
                end
            end
            if (cmd.rd)
                rd_ok_reg <= (fill_reg >= {1'b0, offset_reg});
            if (cmd.emit)
            begin
                wp_reg <= wp_reg + WIN_AW'(1);
                if (fill_reg != FILL_W'(WIN_BYTES))
                    fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    // run registers, loaded on take and counted down on emit
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            byte_reg   <= comp_byte;
            lit_reg    <= stat.go_lit;
            offset_reg <= new_offset;
            bad_reg    <= stat.go_copy && (new_offset == '0);
            if (stat.go_lit)
                remain_reg <= RUN_W'(1);
            else
                remain_reg <= RUN_W'(held_eff & LEN_MASK) + RUN_W'(MIN_MATCH);
        end
        else if (cmd.emit)
            remain_reg <= remain_reg - RUN_W'(1);
    end

    assign stat.last = (remain_reg == RUN_W'(1));

    // history window; entries not yet written since stream start read as zero
    assign rd_addr  = wp_reg - offset_reg;
    assign emit_val = lit_reg ? byte_reg :
                      ((bad_reg || !rd_ok_reg) ? 8'h00 : rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            hist_mem[wp_reg] <= emit_val;
        if (cmd.rd)
            rd_data_reg <= hist_mem[rd_addr];
    end

    // output register
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg   <= emit_val;
            run_last_reg   <= stat.last;
            bad_offset_reg <= bad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign bad_offset = bad_offset_reg;

endmodule

>>> rtl/lzrw1_stream_decompressor.sv
// Top level of the LZRW1 stream decompressor.
//
// Takes one compressed byte per transfer on "compressed" and gives the
// decompressed bytes on "decompressed", one per transfer. Each group of 16
// items is preceded by a 16-bit control word sent low byte first; a control
// bit of 0 is a literal, 1 a two-byte copy item (12-bit offset, length 3..18).
// Parse state and a 4096-byte history window persist between transfers, so a
// stream may arrive in any number of pieces; new_stream set on a byte clears
// the parse state and the history before that byte is parsed. Bytes of a copy
// that reach before the start of the stream read as zero, and a copy with
// offset zero yields zero bytes flagged with bad_offset. run_last marks the
// final output byte that an input byte causes.
// Each byte of a copy run is fetched by a registered history read that
// precedes its write to the window and the output register, and output
// stalls hold the run until the output register is free. The history
// needs no clearing pass: a fill count since the stream start marks which
// window bytes are real, so new_stream takes effect at once.
module lzrw1_stream_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    lzrw_in_if.sink    compressed,
    lzrw_out_if.source decompressed
);
    import lzrw_pkg::*;

    lzrw_cmd_t  cmd;
    lzrw_stat_t stat;

    // sequencer: accepts a byte only when no run is in progress
    lzrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (compressed.valid),
        .in_ready (compressed.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // parse, history and output register
    lzrw_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .comp_byte  (compressed.comp_byte),
        .new_stream (compressed.new_stream),
        .out_valid  (decompressed.valid),
        .out_ready  (decompressed.ready),
        .out_byte   (decompressed.out_byte),
        .run_last   (decompressed.run_last),
        .bad_offset (decompressed.bad_offset)
    );

endmodule

>>> rtl/lzrw_checker.sv
// Port-level checks of the decompressor, bound to the top level.
module lzrw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       bad_offset
);

    // a stalled output keeps its transfer pending
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(run_last)
                                    && $stable(bad_offset))
        else $error("output payload changed while stalled");

    // bytes of a zero-offset copy are zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_offset |-> out_byte == 8'h00)
        else $error("bad_offset byte not zero");

    // input is taken only once the run is complete: a pending byte is its last
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> run_last)
        else $error("input ready during a copy run");

endmodule

bind lzrw1_stream_decompressor lzrw_checker u_lzrw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (compressed.ready),
    .out_valid  (decompressed.valid),
    .out_ready  (decompressed.ready),
    .out_byte   (decompressed.out_byte),
    .run_last   (decompressed.run_last),
    .bad_offset (decompressed.bad_offset)
);

>>> dv/tb_lzrw1_stream_decompressor.sv
// Self-checking testbench for the LZRW1 stream decompressor.
module tb_lzrw1_stream_decompressor;
    import lzrw_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no transfer on either side
    localparam int LONG_HOLD   = 400;   // receiver hold-off for the backpressure test
    localparam int TAIL_CYCLES = 64;    // longer than the longest unstalled copy run
    localparam int RAND_ITEMS  = 80;    // input transfers in the random-stream test; other tests add the rest
    localparam int LONG_OUT    = 768;   // minimum decoded bytes in the long stream test

    // One decompressed byte as it is expected on the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } dec_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Stimulus-side registers, mirrored onto the interfaces below.
    logic       tx_valid = 1'b0;
    logic [7:0] tx_byte  = 8'h00;
    logic       tx_ns    = 1'b0;
    logic       rx_ready = 1'b0;

    lzrw_in_if  comp_if ();
    lzrw_out_if dec_if ();

    assign comp_if.valid      = tx_valid;
    assign comp_if.comp_byte  = tx_byte;
    assign comp_if.new_stream = tx_ns;
    assign dec_if.ready       = rx_ready;

    lzrw1_stream_decompressor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .compressed   (comp_if.sink),
        .decompressed (dec_if.source)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder predictor: its own copy of the parse state and the window.
    // ------------------------------------------------------------------
    logic [15:0] ctrl_shift;      // control bits, consumed from bit 0
    logic [4:0]  items_left;      // items left in the current group
    phase_t      parse_st;
    logic [7:0]  copy_head;       // first byte of a pending copy item
    logic [7:0]  window [WIN_BYTES];
    logic [11:0] win_wr;
    int          stream_out_cnt;  // bytes decoded since the stream start

    dec_byte_t   exp_bytes [$];   // decoded bytes still to come out

    int          err_cnt   = 0;
    int          sent_cnt  = 0;   // accepted input transfers
    int          quiet_cnt = 0;

    task automatic clear_model();
        ctrl_shift     = '0;
        items_left     = '0;
        parse_st       = PH_CTRL_LO;
        copy_head      = '0;
        win_wr         = '0;
        stream_out_cnt = 0;
        foreach (window[i]) window[i] = 8'h00;
    endtask

    task automatic put_window(input logic [7:0] v);
        window[win_wr] = v;
        win_wr         = win_wr + 12'd1;
        stream_out_cnt++;
    endtask

    // Retire one item: shift the control word, drop to a new control word
    // after the sixteenth item.
    task automatic close_item();
        ctrl_shift = ctrl_shift >> 1;
        if (items_left <= 5'd1)
        begin
            items_left = '0;
            parse_st   = PH_CTRL_LO;
        end
        else
        begin
            items_left = items_left - 5'd1;
            parse_st   = PH_ITEM;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic ns);
        logic [11:0] copy_ofs;
        logic [11:0] src;
        logic [7:0]  v;
        int          run_len;
        if (ns)
            clear_model();
        case (parse_st)
            PH_CTRL_LO:
            begin
                ctrl_shift = {8'h00, b};
                parse_st   = PH_CTRL_HI;
            end
            PH_CTRL_HI:
            begin
                ctrl_shift[15:8] = b;
                items_left       = 5'(GROUP_LEN);
                parse_st         = PH_ITEM;
            end
            PH_ITEM:
            begin
                if (ctrl_shift[0])
                begin
                    copy_head = b;
                    parse_st  = PH_COPY2;
                end
                else
                begin
                    put_window(b);
                    exp_bytes.push_back('{data: b, last: 1'b1, bad: 1'b0});
                    close_item();
                end
            end
            default:
            begin
                // Copy: 12-bit offset, length 3..18. Byte by byte so the
                // run may overlap its own output; offset zero gives zeros.
                copy_ofs = {copy_head[7:4], b};
                run_len  = int'(copy_head & LEN_MASK) + MIN_MATCH;
                for (int k = 0; k < run_len; k++)
                begin
                    src = win_wr - copy_ofs;
                    v   = (copy_ofs == 12'd0) ? 8'h00 : window[src];
                    put_window(v);
                    exp_bytes.push_back('{data: v, last: (k == run_len - 1),
                                          bad: (copy_ofs == 12'd0)});
                end
                close_item();
            end
        endcase
    endtask

    // Input monitor: every accepted compressed byte feeds the predictor.
    always @(posedge clk)
    begin
        if (rst_n && comp_if.valid === 1'b1 && comp_if.ready === 1'b1)
            decode_byte(comp_if.comp_byte, comp_if.new_stream);
    end

    // Output checker: each transfer against the oldest expected byte.
    dec_byte_t want;
    always @(posedge clk)
    begin
        if (rst_n && dec_if.valid === 1'b1 && dec_if.ready === 1'b1)
        begin
            if (exp_bytes.size() == 0)
            begin
                if (err_cnt < 10)
                    $display("%0t: output transfer with nothing expected:", $time,
                             " byte %02h last %b bad %b",
                             dec_if.out_byte, dec_if.run_last, dec_if.bad_offset);
                err_cnt++;
            end
            else
            begin
                want = exp_bytes.pop_front();
                if (dec_if.out_byte !== want.data || dec_if.run_last !== want.last ||
                    dec_if.bad_offset !== want.bad)
                begin
                    if (err_cnt < 10)
                        $display("%0t: mismatch: expected byte %02h last %b bad %b,",
                                 $time, want.data, want.last, want.bad,
                                 " got byte %02h last %b bad %b",
                                 dec_if.out_byte, dec_if.run_last, dec_if.bad_offset);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows the bits of a 32-bit pattern in turn, redrawn
    // once all are used (all ready, random, mostly stalled, mostly ready).
    // A toggle of hold_req starts one long hold-off, counted here.
    // ------------------------------------------------------------------
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;
    logic [31:0] rx_pat;
    int          rx_pos = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            rx_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            rx_ready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD - 1;
            rx_ready  <= 1'b0;
        end
        else
        begin
            if (rx_pos == 0)
            begin
                case ($urandom_range(3))
                    0:       rx_pat = '1;
                    1:       rx_pat = $urandom;
                    2:       rx_pat = $urandom & $urandom;
                    default: rx_pat = $urandom | $urandom;
                endcase
            end
            rx_ready <= rx_pat[rx_pos];
            rx_pos    = (rx_pos + 1) % 32;
        end
    end

    // Watchdog: too long with no transfer on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((comp_if.valid === 1'b1 && comp_if.ready === 1'b1) ||
                (dec_if.valid === 1'b1 && dec_if.ready === 1'b1))
                quiet_cnt <= 0;
            else if (quiet_cnt + 1 >= QUIET_LIMIT)
            begin
                $display("tb_lzrw1_stream_decompressor: errors");
                $finish;
            end
            else
                quiet_cnt <= quiet_cnt + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of 1..12 transfers separated by idle gaps, unless
    // tx_steady is set. valid stays high between back-to-back
    // transfers; it is only dropped for a gap or when draining.
    // ------------------------------------------------------------------
    int   tx_burst_left = 0;
    logic tx_steady     = 1'b0;

    task automatic send_byte(input logic [7:0] b, input logic ns);
        int gap;
        gap = 0;
        if (!tx_steady)
        begin
            if (tx_burst_left == 0)
            begin
                gap           = $urandom_range(6, 1);
                tx_burst_left = $urandom_range(12, 1);
            end
            tx_burst_left--;
        end
        if (gap != 0)
        begin
            tx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tx_valid <= 1'b1;
        tx_byte  <= b;
        tx_ns    <= ns;
        do @(posedge clk); while (comp_if.ready !== 1'b1);
        sent_cnt++;
    endtask

    // Drop valid and wait until every predicted byte has come out; the
    // first edge lets the monitor take the last accepted byte.
    task automatic wait_drained();
        tx_valid <= 1'b0;
        @(posedge clk);
        while (exp_bytes.size() != 0) @(posedge clk);
    endtask

    // One well-formed control group: random control word with copy_pct
    // percent copies, then n_items items (fewer than 16 = cut-off group).
    task automatic send_group(input logic ns, input int copy_pct, input int len_lo,
                              input int ofs_hi, input int bad_pct, input int n_items);
        logic [15:0] ctrl;
        logic [11:0] ofs;
        logic [3:0]  len_code;
        for (int i = 0; i < GROUP_LEN; i++)
            ctrl[i] = ($urandom_range(99) < copy_pct);
        send_byte(ctrl[7:0], ns);
        send_byte(ctrl[15:8], 1'b0);
        for (int i = 0; i < n_items; i++)
        begin
            if (!ctrl[i])
                send_byte(8'($urandom), 1'b0);
            else
            begin
                len_code = 4'($urandom_range(15, len_lo));
                ofs      = ($urandom_range(99) < bad_pct) ? 12'd0
                                                          : 12'($urandom_range(ofs_hi, 1));
                send_byte({ofs[11:8], len_code}, 1'b0);
                send_byte(ofs[7:0], 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Parsing straight from reset, byte extremes, shortest and longest
    // copy, overlapping copy, zero offset, reads before the stream
    // start, the end of a control group and a new stream in mid-word.
    task automatic test_directed();
        // control 0x000E: literal, three copies, then twelve literals
        send_byte(8'h0E, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);                       // literal FF
        send_byte(8'h0F, 1'b0); send_byte(8'h01, 1'b0);  // offset 1, 18 bytes: overlap
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);  // offset 0, 3 bytes: flagged
        send_byte(8'hF5, 1'b0); send_byte(8'hFF, 1'b0);  // offset 4095: before start
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0); send_byte(8'h55, 1'b0); send_byte(8'hAA, 1'b0);
        send_byte(8'h10, 1'b0); send_byte(8'h08, 1'b0); send_byte(8'h04, 1'b0);
        send_byte(8'h02, 1'b0); send_byte(8'h40, 1'b0);
        // group done: next byte is a control low byte
        send_byte(8'hFF, 1'b0);
        // new stream where a control high byte was due
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h30, 1'b0); send_byte(8'h00, 1'b0);  // offset 0x300 in a fresh window
        wait_drained();
    endtask

    // One copy-dense stream: offsets reach back across what has been
    // written so far, the later groups anywhere in the window.
    task automatic test_long_stream();
        int ofs_hi;
        tx_steady = 1'b0;
        send_group(1'b1, 95, 12, 64, 2, GROUP_LEN);
        while (stream_out_cnt < LONG_OUT)
        begin
            ofs_hi = (stream_out_cnt < LONG_OUT / 2) ? stream_out_cnt + 16 : WIN_BYTES - 1;
            send_group(1'b0, 95, 12, ofs_hi, 2, GROUP_LEN);
        end
        wait_drained();
    endtask

    // Random streams of 1..4 groups: mixed literal/copy ratio, offsets
    // near, mid or across the full window, some cut-off groups and
    // bursts of raw noise with stray stream restarts.
    task automatic test_random_streams();
        int first_cnt;
        int n_groups;
        int copy_pct;
        int ofs_hi;
        first_cnt = sent_cnt;
        while (sent_cnt - first_cnt < RAND_ITEMS)
        begin
            n_groups  = $urandom_range(4, 1);
            copy_pct  = $urandom_range(90, 10);
            tx_steady = ($urandom_range(3) == 0);
            case ($urandom_range(2))
                0:       ofs_hi = 15;
                1:       ofs_hi = 255;
                default: ofs_hi = WIN_BYTES - 1;
            endcase
            for (int g = 0; g < n_groups; g++)
                send_group(g == 0, copy_pct, 0, ofs_hi, 5,
                           (g == n_groups - 1 && $urandom_range(4) == 0)
                               ? $urandom_range(GROUP_LEN - 1) : GROUP_LEN);
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(6, 1))
                    send_byte(8'($urandom), ($urandom_range(3) == 0));
        end
        tx_steady = 1'b0;
        wait_drained();
    endtask

    // Receiver starts its long hold-off while copy-heavy groups are
    // offered back to back, so the block fills and stalls its input.
    task automatic test_output_backpressure();
        hold_req  <= ~hold_req;
        tx_steady = 1'b1;
        send_group(1'b1, 80, 8, 200, 0, GROUP_LEN);
        send_group(1'b0, 50, 0, WIN_BYTES - 1, 10, GROUP_LEN);
        tx_steady = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        clear_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_stream();
        test_random_streams();
        test_output_backpressure();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_lzrw1_stream_decompressor: clean");
        else
            $display("tb_lzrw1_stream_decompressor: errors");
        $finish;
    end

endmodule

>>> lzrw1_stream_decompressor.f
rtl/lzrw_pkg.sv
rtl/lzrw_in_if.sv
rtl/lzrw_out_if.sv
rtl/lzrw_ctrl.sv
rtl/lzrw_dp.sv
rtl/lzrw1_stream_decompressor.sv
rtl/lzrw_checker.sv
dv/tb_lzrw1_stream_decompressor.sv
